/* design/matrix_congruence_xtax_defines.svh */
// ----------------------------------------------------------------------------
// matrix_congruence_xtax_defines: assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef MATRIX_CONGRUENCE_XTAX_DEFINES_SVH
`define MATRIX_CONGRUENCE_XTAX_DEFINES_SVH

// same-cycle implication
`define MCX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/mcx_pkg.sv */
// ----------------------------------------------------------------------------
// mcx_pkg
// Types and constants shared by the congruence transform modules.
// ----------------------------------------------------------------------------
package mcx_pkg;

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;
  localparam int IdxW     = 6;   // matrix row/col index, covers up to 64
  localparam int KIdxW    = 3;   // result row/col index, covers up to 8

  localparam logic [CfgIdxW-1:0] CFG_N_USED = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_K_USED = 2'd1;

  typedef enum logic [1:0] {
    OP_WRITE_A = 2'd0,
    OP_WRITE_X = 2'd1,
    OP_COMPUTE = 2'd2
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [3:0]         row;
    logic [3:0]         col;
    logic signed [31:0] a_value;
    logic signed [7:0]  x_value;
  } xtax_in_t;

  typedef struct packed {
    logic [2:0]         b_row;
    logic [2:0]         b_col;
    logic signed [63:0] b_value;
    logic               last;
  } xtax_out_t;

  // travels with each product term down the datapath
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             last_entry;
    logic [KIdxW-1:0] i;
    logic [KIdxW-1:0] j;
  } term_tag_t;

  typedef struct packed {
    logic            wr_a;
    logic            wr_x;
    term_tag_t       issue;
    logic [IdxW-1:0] p;
    logic [IdxW-1:0] q;
  } dp_cmd_t;

endpackage

/* design/mcx_datapath.sv */
// ----------------------------------------------------------------------------
// mcx_datapath
// Matrix stores, two-stage product x*a*x and the 64-bit accumulator.
// ----------------------------------------------------------------------------
module mcx_datapath #(
  parameter int MAX_N = 16,
  parameter int MAX_K = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcx_pkg::xtax_in_t  in_i,
  input  mcx_pkg::dp_cmd_t   cmd_i,
  output logic               acc_done_o,
  output logic               res_valid_o,
  output mcx_pkg::xtax_out_t res_o
);

  localparam int NW     = $clog2(MAX_N);
  localparam int KW     = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int ADepth = 1 << (2 * NW);
  localparam int XDepth = 1 << (NW + KW);

  logic signed [31:0] a_mem [ADepth];
  logic signed [7:0]  x_mem [XDepth];

  logic [2*NW-1:0]    a_wr_addr, a_rd_addr;
  logic [NW+KW-1:0]   x_wr_addr, xp_rd_addr, xq_rd_addr;

  logic signed [31:0] a_rd_q;
  logic signed [7:0]  xp_rd_q, xq_rd_q, xq_s2_q;
  logic signed [39:0] m1_d, m1_q;
  logic signed [47:0] m2_d, m2_q;
  logic signed [63:0] sum_c, acc_q;

  mcx_pkg::term_tag_t  s1_tag_q, s2_tag_q, s3_tag_q;
  mcx_pkg::xtax_out_t  res_d, res_q;
  logic                res_valid_q;

  assign a_wr_addr  = {NW'(in_i.row), NW'(in_i.col)};
  assign x_wr_addr  = {NW'(in_i.row), KW'(in_i.col)};
  assign a_rd_addr  = {cmd_i.p[NW-1:0], cmd_i.q[NW-1:0]};
  assign xp_rd_addr = {cmd_i.p[NW-1:0], cmd_i.issue.i[KW-1:0]};
  assign xq_rd_addr = {cmd_i.q[NW-1:0], cmd_i.issue.j[KW-1:0]};

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a) begin
      a_mem[a_wr_addr] <= in_i.a_value;
    end
    a_rd_q <= a_mem[a_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_x) begin
      x_mem[x_wr_addr] <= in_i.x_value;
    end
    xp_rd_q <= x_mem[xp_rd_addr];
    xq_rd_q <= x_mem[xq_rd_addr];
  end

  assign m1_d  = 40'(xp_rd_q) * 40'(a_rd_q);
  assign m2_d  = 48'(m1_q) * 48'(xq_s2_q);
  assign sum_c = s3_tag_q.first ? 64'(m2_q) : acc_q + 64'(m2_q);

  always_comb begin
    res_d         = res_q;
    res_d.b_row   = s3_tag_q.i;
    res_d.b_col   = s3_tag_q.j;
    res_d.b_value = sum_c;
    res_d.last    = s3_tag_q.last_entry;
  end

  always_ff @(posedge clk_i) begin
    m1_q    <= m1_d;
    xq_s2_q <= xq_rd_q;
    m2_q    <= m2_d;
    if (s3_tag_q.valid && s3_tag_q.last_term) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_tag_q    <= '0;
      s2_tag_q    <= '0;
      s3_tag_q    <= '0;
      acc_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      s1_tag_q    <= cmd_i.issue;
      s2_tag_q    <= s1_tag_q;
      s3_tag_q    <= s2_tag_q;
      if (s3_tag_q.valid) begin
        acc_q <= sum_c;
      end
      res_valid_q <= s3_tag_q.valid && s3_tag_q.last_term;
    end
  end

  assign acc_done_o  = s3_tag_q.valid && s3_tag_q.last_entry;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

/* design/mcx_ctrl.sv */
// ----------------------------------------------------------------------------
// mcx_ctrl
// Command decode and term sequencer over entries (i, j) and terms (p, q).
// ----------------------------------------------------------------------------
module mcx_ctrl #(
  parameter int MAX_N = 16,
  parameter int MAX_K = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  mcx_pkg::xtax_in_t in_i,
  input  logic [4:0]        n_used_i,
  input  logic [3:0]        k_used_i,
  input  logic              acc_done_i,
  output logic              busy_o,
  output mcx_pkg::dp_cmd_t  cmd_o
);

  localparam int NW = $clog2(MAX_N);
  localparam int KW = (MAX_K > 1) ? $clog2(MAX_K) : 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_RUN   = 3'b010,
    S_DRAIN = 3'b100
  } state_e;

  state_e        state_q, state_d;
  logic [NW-1:0] p_q, p_d, q_q, q_d, n_lim_q, n_lim_d, n_lim_c;
  logic [KW-1:0] i_q, i_d, j_q, j_d, k_lim_q, k_lim_d, k_lim_c;
  logic          last_term, last_entry;

  always_comb begin
    if (n_used_i == '0) begin
      n_lim_c = '0;
    end else if (32'(n_used_i) > MAX_N) begin
      n_lim_c = NW'(MAX_N - 1);
    end else begin
      n_lim_c = NW'(n_used_i - 5'd1);
    end
    if (k_used_i == '0) begin
      k_lim_c = '0;
    end else if (32'(k_used_i) > MAX_K) begin
      k_lim_c = KW'(MAX_K - 1);
    end else begin
      k_lim_c = KW'(k_used_i - 4'd1);
    end
  end

  assign last_term  = (p_q == n_lim_q) && (q_q == n_lim_q);
  assign last_entry = last_term && (i_q == k_lim_q) && (j_q == k_lim_q);

  always_comb begin
    state_d = state_q;
    p_d     = p_q;
    q_d     = q_q;
    i_d     = i_q;
    j_d     = j_q;
    n_lim_d = n_lim_q;
    k_lim_d = k_lim_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (in_i.op)
            mcx_pkg::OP_WRITE_A: begin
              cmd_o.wr_a = (32'(in_i.row) < MAX_N) && (32'(in_i.col) < MAX_N);
            end
            mcx_pkg::OP_WRITE_X: begin
              cmd_o.wr_x = (32'(in_i.row) < MAX_N) && (32'(in_i.col) < MAX_K);
            end
            mcx_pkg::OP_COMPUTE: begin
              n_lim_d = n_lim_c;
              k_lim_d = k_lim_c;
              p_d     = '0;
              q_d     = '0;
              i_d     = '0;
              j_d     = '0;
              state_d = S_RUN;
            end
            default: ;
          endcase
        end
      end
      S_RUN: begin
        cmd_o.p                = mcx_pkg::IdxW'(p_q);
        cmd_o.q                = mcx_pkg::IdxW'(q_q);
        cmd_o.issue.valid      = 1'b1;
        cmd_o.issue.first      = (p_q == '0) && (q_q == '0);
        cmd_o.issue.last_term  = last_term;
        cmd_o.issue.last_entry = last_entry;
        cmd_o.issue.i          = mcx_pkg::KIdxW'(i_q);
        cmd_o.issue.j          = mcx_pkg::KIdxW'(j_q);
        if (q_q != n_lim_q) begin
          q_d = q_q + 1'b1;
        end else begin
          q_d = '0;
          if (p_q != n_lim_q) begin
            p_d = p_q + 1'b1;
          end else begin
            p_d = '0;
            if (j_q != k_lim_q) begin
              j_d = j_q + 1'b1;
            end else begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end
          end
        end
        if (last_entry) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (acc_done_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      q_q     <= '0;
      i_q     <= '0;
      j_q     <= '0;
      n_lim_q <= '0;
      k_lim_q <= '0;
    end else begin
      state_q <= state_d;
      p_q     <= p_d;
      q_q     <= q_d;
      i_q     <= i_d;
      j_q     <= j_d;
      n_lim_q <= n_lim_d;
      k_lim_q <= k_lim_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* design/matrix_congruence_xtax.sv */
// ----------------------------------------------------------------------------
// matrix_congruence_xtax
// Congruence transform b = x' * a * x with loadable a (Q16.16) and x (int8).
//
// channel   handshake                     payload
// in        start_i && !busy_o            in_i    (op, row, col, a_value, x_value)
// result    res_valid_o, no back-pressure res_o   (b_row, b_col, b_value, last)
// config    cfg_valid_i && cfg_ready_o    cfg_index_i, cfg_data_i
//
// a load beat never raises busy_o
// a compute beat issues one product term per cycle, set by the single
// multiply-accumulate path; busy_o drops as the last term leaves the s3 tag stage
// results appear once per entry (i, j); the last one shows the cycle busy_o drops
// reset leaves n_used = 16, k_used = 8; matrix stores are not cleared
// ----------------------------------------------------------------------------
`include "matrix_congruence_xtax_defines.svh"

module matrix_congruence_xtax #(
  parameter int MAX_N = 16,
  parameter int MAX_K = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  mcx_pkg::xtax_in_t               in_i,
  output logic                            res_valid_o,
  output mcx_pkg::xtax_out_t              res_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcx_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [mcx_pkg::CfgDataW-1:0]    cfg_data_i
);

  logic [4:0]       n_used_q, n_used_d;
  logic [3:0]       k_used_q, k_used_d;
  logic             acc_done;
  mcx_pkg::dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    n_used_d = n_used_q;
    k_used_d = k_used_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        mcx_pkg::CFG_N_USED: n_used_d = 5'(cfg_data_i);
        mcx_pkg::CFG_K_USED: k_used_d = 4'(cfg_data_i);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_used_q <= 5'd16;
      k_used_q <= 4'd8;
    end else begin
      n_used_q <= n_used_d;
      k_used_q <= k_used_d;
    end
  end

  mcx_ctrl #(
    .MAX_N(MAX_N),
    .MAX_K(MAX_K)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .n_used_i   (n_used_q),
    .k_used_i   (k_used_q),
    .acc_done_i (acc_done),
    .busy_o     (busy_o),
    .cmd_o      (cmd)
  );

  mcx_datapath #(
    .MAX_N(MAX_N),
    .MAX_K(MAX_K)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .acc_done_o  (acc_done),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  `MCX_ASSERT_NEXT(a_compute_busy, start_i && !busy_o && (in_i.op == mcx_pkg::OP_COMPUTE), busy_o, "compute beat did not raise busy")
  `MCX_ASSERT_IMPL(a_mid_result_busy, res_valid_o && !res_o.last, busy_o, "intermediate result while idle")
  `MCX_ASSERT_IMPL(a_last_result_idle, res_valid_o && res_o.last, !busy_o, "busy after last result")
  `MCX_ASSERT_IMPL(a_busy_fall_last, $fell(busy_o), res_valid_o && res_o.last, "busy dropped without last result")

endmodule

/* sim/matrix_congruence_xtax_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_congruence_xtax_tb
// Loads a and x through the command port and checks every emitted entry of
// b = x' * a * x against an in-bench model of both stores and the registers.
// A short table covers the extremes, ignored writes, the spare opcode and the
// register limits; random phases follow with random sizes and gaps.
// ----------------------------------------------------------------------------
module matrix_congruence_xtax_tb;

  localparam int MaxN       = 16;
  localparam int MaxK       = 8;
  localparam int CycleLimit = 1000000;
  localparam int ItemTarget = 160;

  localparam logic [mcx_pkg::CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [mcx_pkg::CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam mcx_pkg::op_e                OP_SPARE     = mcx_pkg::op_e'(2'd3);

  typedef struct packed {
    logic                         is_cfg;
    logic [mcx_pkg::CfgIdxW-1:0]  reg_idx;
    logic [mcx_pkg::CfgDataW-1:0] reg_dat;
    mcx_pkg::xtax_in_t            beat;
    logic                         has_b;
    logic signed [63:0]           b_val;
  } plan_row_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         start_i     = 1'b0;
  mcx_pkg::xtax_in_t            in_i        = '0;
  logic                         cfg_valid_i = 1'b0;
  logic [mcx_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [mcx_pkg::CfgDataW-1:0] cfg_data_i  = '0;
  logic                         busy_o;
  logic                         res_valid_o;
  mcx_pkg::xtax_out_t           res_o;
  logic                         cfg_ready_o;

  logic signed [31:0] a_mirror  [MaxN][MaxN];
  logic signed [7:0]  x_mirror  [MaxN][MaxK];
  bit                 a_loaded  [MaxN][MaxN];
  bit                 x_loaded  [MaxN][MaxK];
  logic [4:0]         n_cfg = 5'd16;
  logic [3:0]         k_cfg = 4'd8;

  mcx_pkg::xtax_out_t b_expect_q [$];
  plan_row_t          plan_q [$];
  int unsigned        flaws      = 0;
  int unsigned        cycle_cnt  = 0;
  int unsigned        beats_sent = 0;

  matrix_congruence_xtax #(
    .MAX_N(MaxN),
    .MAX_K(MaxK)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .in_i       (in_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    mcx_pkg::xtax_out_t want;
    if (rst_ni && res_valid_o) begin
      if (b_expect_q.size() == 0) begin
        if (flaws < 10)
          $display("unexpected entry b[%0d][%0d] = %0d last %0b",
                   res_o.b_row, res_o.b_col, res_o.b_value, res_o.last);
        flaws++;
      end else begin
        want = b_expect_q.pop_front();
        if (res_o.b_row !== want.b_row || res_o.b_col !== want.b_col ||
            res_o.b_value !== want.b_value || res_o.last !== want.last) begin
          if (flaws < 10)
            $display("mismatch: want b[%0d][%0d] = %0d last %0b, got b[%0d][%0d] = %0d last %0b",
                     want.b_row, want.b_col, want.b_value, want.last,
                     res_o.b_row, res_o.b_col, res_o.b_value, res_o.last);
          flaws++;
        end
      end
    end
  end

  function automatic int unsigned eff_n();
    return (n_cfg == 0) ? 1 : ((n_cfg > MaxN) ? MaxN : n_cfg);
  endfunction

  function automatic int unsigned eff_k();
    return (k_cfg == 0) ? 1 : ((k_cfg > MaxK) ? MaxK : k_cfg);
  endfunction

  function automatic int unsigned pick_gap(bit steady);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] rand_a();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return 32'($urandom_range(0, 255)) << 16;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic signed [7:0] rand_x();
    case ($urandom_range(0, 5))
      0: return 8'sh80;
      1: return 8'sh7F;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic mcx_pkg::xtax_in_t mk_beat(mcx_pkg::op_e op, logic [3:0] row,
                                                logic [3:0] col, logic signed [31:0] a,
                                                logic signed [7:0] x);
    mcx_pkg::xtax_in_t beat;
    beat.op      = op;
    beat.row     = row;
    beat.col     = col;
    beat.a_value = a;
    beat.x_value = x;
    return beat;
  endfunction

  function automatic plan_row_t cfg_row(logic [mcx_pkg::CfgIdxW-1:0] idx,
                                        logic [mcx_pkg::CfgDataW-1:0] dat);
    plan_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_dat = dat;
    return r;
  endfunction

  function automatic plan_row_t item_row(mcx_pkg::op_e op, logic [3:0] row, logic [3:0] col,
                                         logic signed [31:0] a, logic signed [7:0] x,
                                         logic has_b, logic signed [63:0] b_val);
    plan_row_t r;
    r       = '0;
    r.beat  = mk_beat(op, row, col, a, x);
    r.has_b = has_b;
    r.b_val = b_val;
    return r;
  endfunction

  task automatic drive_beat(mcx_pkg::xtax_in_t beat, bit steady, bit typed,
                            logic signed [63:0] typed_b);
    int unsigned        n, k, gap;
    longint             acc;
    mcx_pkg::xtax_out_t r;
    start_i <= 1'b1;
    in_i    <= beat;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    beats_sent++;
    case (beat.op)
      mcx_pkg::OP_WRITE_A: begin
        a_mirror[beat.row][beat.col] = beat.a_value;
        a_loaded[beat.row][beat.col] = 1'b1;
      end
      mcx_pkg::OP_WRITE_X: begin
        if (beat.col < MaxK) begin
          x_mirror[beat.row][beat.col] = beat.x_value;
          x_loaded[beat.row][beat.col] = 1'b1;
        end
      end
      mcx_pkg::OP_COMPUTE: begin
        if (typed) begin
          r.b_row   = '0;
          r.b_col   = '0;
          r.b_value = typed_b;
          r.last    = 1'b1;
          b_expect_q.push_back(r);
        end else begin
          n = eff_n();
          k = eff_k();
          for (int unsigned i = 0; i < k; i++) begin
            for (int unsigned j = 0; j < k; j++) begin
              acc = 0;
              for (int unsigned p = 0; p < n; p++)
                for (int unsigned q = 0; q < n; q++)
                  acc += longint'(x_mirror[p][i]) * longint'(a_mirror[p][q]) *
                         longint'(x_mirror[q][j]);
              r.b_row   = 3'(i);
              r.b_col   = 3'(j);
              r.b_value = acc;
              r.last    = (i == k - 1) && (j == k - 1);
              b_expect_q.push_back(r);
            end
          end
        end
      end
      default: ;
    endcase
    gap = pick_gap(steady);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // every entry a compute will read gets a value first
  task automatic fill_missing(bit steady);
    int unsigned n, k;
    n = eff_n();
    k = eff_k();
    for (int unsigned p = 0; p < n; p++)
      for (int unsigned q = 0; q < n; q++)
        if (!a_loaded[p][q])
          drive_beat(mk_beat(mcx_pkg::OP_WRITE_A, 4'(p), 4'(q), rand_a(), rand_x()),
                     steady, 0, '0);
    for (int unsigned p = 0; p < n; p++)
      for (int unsigned c = 0; c < k; c++)
        if (!x_loaded[p][c])
          drive_beat(mk_beat(mcx_pkg::OP_WRITE_X, 4'(p), 4'(c), rand_a(), rand_x()),
                     steady, 0, '0);
  endtask

  task automatic settle_block();
    start_i <= 1'b0;
    while (b_expect_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [mcx_pkg::CfgIdxW-1:0] idx,
                           logic [mcx_pkg::CfgDataW-1:0] dat, bit hold);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= dat;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      mcx_pkg::CFG_N_USED: n_cfg = dat[4:0];
      mcx_pkg::CFG_K_USED: k_cfg = dat[3:0];
      default: ;
    endcase
    if (!hold) begin
      cfg_valid_i <= 1'b0;
      repeat (1 + pick_gap(0)) @(posedge clk_i);
    end
  endtask

  initial begin
    plan_row_t         pr;
    mcx_pkg::xtax_in_t beat;
    int unsigned       n, k;
    logic [7:0]        n_dat, k_dat;
    bit                steady, hold;

    plan_q.push_back(cfg_row(mcx_pkg::CFG_N_USED, 8'd1));
    plan_q.push_back(cfg_row(mcx_pkg::CFG_K_USED, 8'd1));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'sh0001_0000, 8'sh00, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'd0, 4'd0, 32'sh0000_0000, 8'sh01, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'sh0, 8'sh0, 1,
                              64'sh0000_0000_0001_0000));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'sh8000_0000, 8'sh00, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'd0, 4'd0, 32'sh0000_0000, 8'sh80, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'hF, 4'hF, 32'shFFFF_FFFF, 8'shFF, 1,
                              64'shFFFF_E000_0000_0000));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_A, 4'd0, 4'd0, 32'sh7FFF_FFFF, 8'sh7F, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'd0, 4'd0, 32'sh7FFF_FFFF, 8'sh7F, 0,
                              '0));
    // x column past the last one is dropped
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'd0, 4'hF, 32'sh0, 8'shFF, 0, '0));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'hF, 4'd8, 32'sh0, 8'sh55, 0, '0));
    plan_q.push_back(item_row(OP_SPARE, 4'hF, 4'hF, 32'shFFFF_FFFF, 8'shFF, 0, '0));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'sh0, 8'sh0, 1,
                              64'sh0000_1F80_7FFF_C0FF));
    // zero sizes act as one, spare register indexes are dropped
    plan_q.push_back(cfg_row(mcx_pkg::CFG_N_USED, 8'd0));
    plan_q.push_back(cfg_row(mcx_pkg::CFG_K_USED, 8'd0));
    plan_q.push_back(cfg_row(CFG_SPARE_LO, 8'hFF));
    plan_q.push_back(cfg_row(CFG_SPARE_HI, 8'hFF));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'sh0, 8'sh0, 1,
                              64'sh0000_1F80_7FFF_C0FF));
    plan_q.push_back(cfg_row(mcx_pkg::CFG_N_USED, 8'd2));
    plan_q.push_back(cfg_row(mcx_pkg::CFG_K_USED, 8'd2));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_A, 4'd1, 4'd1, 32'shFFFF_FFFF, 8'sh00, 0,
                              '0));
    plan_q.push_back(item_row(mcx_pkg::OP_WRITE_X, 4'd1, 4'd1, 32'sh0, 8'sh80, 0, '0));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'sh0, 8'sh0, 0, '0));
    // high register bits are dropped, oversized k saturates to the full width
    plan_q.push_back(cfg_row(mcx_pkg::CFG_N_USED, 8'hE2));
    plan_q.push_back(cfg_row(mcx_pkg::CFG_K_USED, 8'hFF));
    plan_q.push_back(item_row(mcx_pkg::OP_COMPUTE, 4'd0, 4'd0, 32'sh0, 8'sh0, 0, '0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan_q[idx]) begin
      pr = plan_q[idx];
      if (pr.is_cfg) begin
        settle_block();
        write_reg(pr.reg_idx, pr.reg_dat, 0);
      end else begin
        if (pr.beat.op == mcx_pkg::OP_COMPUTE)
          fill_missing(0);
        drive_beat(pr.beat, 0, pr.has_b, pr.b_val);
      end
    end

    while (beats_sent < ItemTarget) begin
      settle_block();
      n_dat = {3'($urandom), 5'($urandom_range(0, 5))};
      if ($urandom_range(0, 7) == 0)
        k_dat = 8'($urandom);
      else
        k_dat = {4'($urandom), 4'($urandom_range(0, 3))};
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 8'($urandom), 0);
      hold = $urandom_range(0, 1);
      if ($urandom_range(0, 1)) begin
        write_reg(mcx_pkg::CFG_N_USED, n_dat, hold);
        write_reg(mcx_pkg::CFG_K_USED, k_dat, 0);
      end else begin
        write_reg(mcx_pkg::CFG_K_USED, k_dat, hold);
        write_reg(mcx_pkg::CFG_N_USED, n_dat, 0);
      end
      steady = ($urandom_range(0, 3) == 0);
      n = eff_n();
      k = eff_k();
      repeat ($urandom_range(1, 2)) begin
        repeat ($urandom_range(1, 8)) begin
          if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 2))
              0: beat = mk_beat(OP_SPARE, 4'($urandom), 4'($urandom), 32'($urandom),
                                8'($urandom));
              1: beat = mk_beat(mcx_pkg::OP_WRITE_A, 4'($urandom), 4'($urandom), rand_a(),
                                8'($urandom));
              default: beat = mk_beat(mcx_pkg::OP_WRITE_X, 4'($urandom), 4'($urandom),
                                      32'($urandom), rand_x());
            endcase
          end else if ($urandom_range(0, 1)) begin
            beat = mk_beat(mcx_pkg::OP_WRITE_A, 4'($urandom_range(0, n - 1)),
                           4'($urandom_range(0, n - 1)), rand_a(), 8'($urandom));
          end else begin
            beat = mk_beat(mcx_pkg::OP_WRITE_X, 4'($urandom_range(0, n - 1)),
                           4'($urandom_range(0, k - 1)), 32'($urandom), rand_x());
          end
          drive_beat(beat, steady, 0, '0);
        end
        fill_missing(steady);
        drive_beat(mk_beat(mcx_pkg::OP_COMPUTE, 4'($urandom), 4'($urandom), 32'($urandom),
                           8'($urandom)), steady, 0, '0);
      end
    end

    settle_block();
    if (flaws == 0 && b_expect_q.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
